@@ design/uadp_pkg.sv @@
// Shared constants, register map and widths for the upwind advection-diffusion point update.
package uadp_pkg;

    localparam int DataW   = 32;
    localparam int GainW   = 31;
    localparam int ApbW    = 32;
    localparam int AddrW   = 5;
    localparam int DiffW   = DataW + 1;
    localparam int LapW    = DataW + 2;
    localparam int ScaledW = GainW + DataW;
    localparam int AdvW    = ScaledW + DiffW;
    localparam int Sum32W  = GainW + LapW + 2;
    localparam int AccW    = AdvW + 4;
    localparam int Stages  = 6;

    typedef enum logic [2:0] {
        REG_ADV_GAIN_X       = 3'd0,
        REG_ADV_GAIN_Y       = 3'd1,
        REG_VORT_DIFF_GAIN_X = 3'd2,
        REG_VORT_DIFF_GAIN_Y = 3'd3,
        REG_TEMP_DIFF_GAIN_X = 3'd4,
        REG_TEMP_DIFF_GAIN_Y = 3'd5,
        REG_BUOYANCY_GAIN    = 3'd6
    } reg_idx_t;

    localparam logic OP_VORTICITY   = 1'b0;
    localparam logic OP_TEMPERATURE = 1'b1;

    localparam logic [GainW-1:0] ADV_GAIN_RESET  = 31'd6554;
    localparam logic [GainW-1:0] DIFF_GAIN_RESET = 31'd1311;
    localparam logic [GainW-1:0] BUOY_GAIN_RESET = 31'd32768;

    localparam logic [DataW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SAT_MIN = 32'h8000_0000;

endpackage

@@ design/uadp_ifs.sv @@
// Valid/ready channel interfaces for input items and result words.
interface uadp_item_if import uadp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic signed [DataW-1:0] center_value;
    logic signed [DataW-1:0] west_value;
    logic signed [DataW-1:0] east_value;
    logic signed [DataW-1:0] south_value;
    logic signed [DataW-1:0] north_value;
    logic signed [DataW-1:0] x_velocity;
    logic signed [DataW-1:0] y_velocity;
    logic signed [DataW-1:0] temp_west;
    logic signed [DataW-1:0] temp_east;

    modport source (
        output valid, opcode, center_value, west_value, east_value, south_value,
               north_value, x_velocity, y_velocity, temp_west, temp_east,
        input  ready
    );
    modport sink (
        input  valid, opcode, center_value, west_value, east_value, south_value,
               north_value, x_velocity, y_velocity, temp_west, temp_east,
        output ready
    );
endinterface

interface uadp_result_if import uadp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] new_value;
    logic                    saturated;

    modport source (output valid, new_value, saturated, input ready);
    modport sink (input valid, new_value, saturated, output ready);
endinterface

@@ design/upwind_advection_diffusion_point.sv @@
// Pipelined Q16.16 upwind advection-diffusion update of one grid point.
// Six register stages; the result word comes from the stage 6 output register.
// Throughput: one item per cycle while the result is taken; every stage is a register with its own valid bit,
// and a stalled result only blocks stages that are full (bubbles are squeezed out).
// Reset (rst_n low, asynchronous): all valid bits clear, gains return to defaults.
// Payload registers are not reset.
module upwind_advection_diffusion_point import uadp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    uadp_item_if.sink        item,
    uadp_result_if.source    result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [ApbW-1:0]  pwdata,
    output logic [ApbW-1:0]  prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Gain registers (APB). Register i sits at byte address 4*i; the low
    // address bits are ignored and the unused slot drops writes.
    // ------------------------------------------------------------------
    logic [GainW-1:0] adv_gain_x_reg, adv_gain_y_reg;
    logic [GainW-1:0] vort_gain_x_reg, vort_gain_y_reg;
    logic [GainW-1:0] temp_gain_x_reg, temp_gain_y_reg;
    logic [GainW-1:0] buoy_gain_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[AddrW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_gain_x_reg  <= ADV_GAIN_RESET;
            adv_gain_y_reg  <= ADV_GAIN_RESET;
            vort_gain_x_reg <= DIFF_GAIN_RESET;
            vort_gain_y_reg <= DIFF_GAIN_RESET;
            temp_gain_x_reg <= DIFF_GAIN_RESET;
            temp_gain_y_reg <= DIFF_GAIN_RESET;
            buoy_gain_reg   <= BUOY_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ADV_GAIN_X:       adv_gain_x_reg  <= pwdata[GainW-1:0];
                REG_ADV_GAIN_Y:       adv_gain_y_reg  <= pwdata[GainW-1:0];
                REG_VORT_DIFF_GAIN_X: vort_gain_x_reg <= pwdata[GainW-1:0];
                REG_VORT_DIFF_GAIN_Y: vort_gain_y_reg <= pwdata[GainW-1:0];
                REG_TEMP_DIFF_GAIN_X: temp_gain_x_reg <= pwdata[GainW-1:0];
                REG_TEMP_DIFF_GAIN_Y: temp_gain_y_reg <= pwdata[GainW-1:0];
                REG_BUOYANCY_GAIN:    buoy_gain_reg   <= pwdata[GainW-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ADV_GAIN_X:       prdata = {1'b0, adv_gain_x_reg};
            REG_ADV_GAIN_Y:       prdata = {1'b0, adv_gain_y_reg};
            REG_VORT_DIFF_GAIN_X: prdata = {1'b0, vort_gain_x_reg};
            REG_VORT_DIFF_GAIN_Y: prdata = {1'b0, vort_gain_y_reg};
            REG_TEMP_DIFF_GAIN_X: prdata = {1'b0, temp_gain_x_reg};
            REG_TEMP_DIFF_GAIN_Y: prdata = {1'b0, temp_gain_y_reg};
            REG_BUOYANCY_GAIN:    prdata = {1'b0, buoy_gain_reg};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control. Stage k loads when it is empty or stage k+1 loads;
    // the last stage is the output register and loads when the result
    // word is taken or absent.
    // ------------------------------------------------------------------
    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] load;

    always_comb
    begin
        load[Stages-1] = !valid_reg[Stages-1] || result.ready;
        for (int k = Stages - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign item.ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= item.valid;
            end
            for (int k = 1; k < Stages; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: upwind differences, Laplacian parts, temperature gradient,
    // gain selection by opcode and the gain-scaled velocities.
    // ------------------------------------------------------------------
    logic signed [DataW-1:0]   s1_c_reg;
    logic signed [DiffW-1:0]   s1_ddx_reg, s1_ddy_reg, s1_tdiff_reg;
    logic signed [LapW-1:0]    s1_lapx_reg, s1_lapy_reg;
    logic signed [ScaledW-1:0] s1_pux_reg, s1_pvy_reg;
    logic [GainW-1:0]          s1_gdx_reg, s1_gdy_reg, s1_bg_reg;

    logic signed [DiffW-1:0]   ddx_next, ddy_next, tdiff_next;
    logic signed [LapW-1:0]    lapx_next, lapy_next;
    logic signed [ScaledW-1:0] pux_full, pvy_full;
    logic                      u_pos, v_pos, temp_op;
    logic signed [DiffW-1:0]   c33, w33, e33, s33, n33;
    logic signed [LapW-1:0]    c2_34;

    always_comb
    begin
        temp_op = (item.opcode == OP_TEMPERATURE);
        u_pos   = !item.x_velocity[DataW-1] && (item.x_velocity != '0);
        v_pos   = !item.y_velocity[DataW-1] && (item.y_velocity != '0);
        c33     = DiffW'(item.center_value);
        w33     = DiffW'(item.west_value);
        e33     = DiffW'(item.east_value);
        s33     = DiffW'(item.south_value);
        n33     = DiffW'(item.north_value);
        c2_34   = {c33, 1'b0};
        // Backward difference for positive velocity, forward otherwise.
        ddx_next   = u_pos ? (c33 - w33) : (e33 - c33);
        ddy_next   = v_pos ? (c33 - s33) : (n33 - c33);
        lapx_next  = LapW'(e33) - c2_34 + LapW'(w33);
        lapy_next  = LapW'(n33) - c2_34 + LapW'(s33);
        tdiff_next = DiffW'(item.temp_east) - DiffW'(item.temp_west);
        // Non-negative 31-bit gain times signed 32-bit velocity fits 63 bits.
        pux_full   = ScaledW'($signed({1'b0, adv_gain_x_reg})) * ScaledW'(item.x_velocity);
        pvy_full   = ScaledW'($signed({1'b0, adv_gain_y_reg})) * ScaledW'(item.y_velocity);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_c_reg     <= item.center_value;
            s1_ddx_reg   <= ddx_next;
            s1_ddy_reg   <= ddy_next;
            s1_lapx_reg  <= lapx_next;
            s1_lapy_reg  <= lapy_next;
            s1_tdiff_reg <= tdiff_next;
            s1_pux_reg   <= pux_full;
            s1_pvy_reg   <= pvy_full;
            s1_gdx_reg   <= temp_op ? temp_gain_x_reg : vort_gain_x_reg;
            s1_gdy_reg   <= temp_op ? temp_gain_y_reg : vort_gain_y_reg;
            // Temperature has no buoyancy source: zero its gain.
            s1_bg_reg    <= temp_op ? '0 : buoy_gain_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: all products. The 63-bit scaled velocity times the 33-bit
    // difference is split into a high and a low half partial product.
    // ------------------------------------------------------------------
    localparam int HiW = ScaledW - DataW;
    localparam int MhW = HiW + DiffW;
    localparam int MlW = 2 * DiffW;
    localparam int DfW = GainW + 1 + LapW;
    localparam int BuW = GainW + 1 + DiffW;

    logic signed [DataW-1:0] s2_c_reg;
    logic signed [MhW-1:0]   s2_mxh_reg, s2_myh_reg;
    logic signed [MlW-1:0]   s2_mxl_reg, s2_myl_reg;
    logic signed [DfW-1:0]   s2_dfx_reg, s2_dfy_reg;
    logic signed [BuW-1:0]   s2_bu_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_c_reg   <= s1_c_reg;
            s2_mxh_reg <= MhW'($signed(s1_pux_reg[ScaledW-1:DataW])) * MhW'(s1_ddx_reg);
            s2_myh_reg <= MhW'($signed(s1_pvy_reg[ScaledW-1:DataW])) * MhW'(s1_ddy_reg);
            s2_mxl_reg <= MlW'($signed({1'b0, s1_pux_reg[DataW-1:0]})) * MlW'(s1_ddx_reg);
            s2_myl_reg <= MlW'($signed({1'b0, s1_pvy_reg[DataW-1:0]})) * MlW'(s1_ddy_reg);
            s2_dfx_reg <= DfW'($signed({1'b0, s1_gdx_reg})) * DfW'(s1_lapx_reg);
            s2_dfy_reg <= DfW'($signed({1'b0, s1_gdy_reg})) * DfW'(s1_lapy_reg);
            s2_bu_reg  <= BuW'($signed({1'b0, s1_bg_reg})) * BuW'(s1_tdiff_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: recombine advection partial products; sum the 2^-32 terms.
    // ------------------------------------------------------------------
    logic signed [DataW-1:0]  s3_c_reg;
    logic signed [AdvW-1:0]   s3_advx_reg, s3_advy_reg;
    logic signed [Sum32W-1:0] s3_sum_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_c_reg    <= s2_c_reg;
            s3_advx_reg <= AdvW'({s2_mxh_reg, {DataW{1'b0}}}) + AdvW'(s2_mxl_reg);
            s3_advy_reg <= AdvW'({s2_myh_reg, {DataW{1'b0}}}) + AdvW'(s2_myl_reg);
            s3_sum_reg  <= Sum32W'(s2_dfx_reg) + Sum32W'(s2_dfy_reg)
                           - Sum32W'(s2_bu_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: align everything to 2^-48 and form two partial sums; the
    // rounding half LSB rides with the center term. Sign-extend the
    // shifted center and diffusion sum.
    // ------------------------------------------------------------------
    localparam logic signed [AccW-1:0] RoundHalf = AccW'(64'h8000_0000);

    logic signed [AccW-1:0] s4_a_reg, s4_b_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_a_reg <= AccW'($signed({s3_c_reg, {DataW{1'b0}}})) + RoundHalf
                        - AccW'(s3_advx_reg);
            s4_b_reg <= AccW'($signed({s3_sum_reg, 16'b0})) - AccW'(s3_advy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: final exact sum.
    // ------------------------------------------------------------------
    logic signed [AccW-1:0] s5_acc_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_acc_reg <= s4_a_reg + s4_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6 (output register): drop the low 32 fraction bits and clamp.
    // In range when every bit above the Q16.16 sign bit matches it.
    // ------------------------------------------------------------------
    logic signed [DataW-1:0] new_value_reg;
    logic                    saturated_reg;
    logic                    in_range;

    assign in_range = (s5_acc_reg[AccW-1:2*DataW-1] == '0)
                   || (s5_acc_reg[AccW-1:2*DataW-1] == '1);

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            if (in_range)
            begin
                new_value_reg <= s5_acc_reg[2*DataW-1:DataW];
                saturated_reg <= 1'b0;
            end
            else
            begin
                new_value_reg <= s5_acc_reg[AccW-1] ? SAT_MIN : SAT_MAX;
                saturated_reg <= 1'b1;
            end
        end
    end

    assign result.valid     = valid_reg[Stages-1];
    assign result.new_value = new_value_reg;
    assign result.saturated = saturated_reg;

`ifndef SYNTHESIS
    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> valid_reg[0])
        else $error("accepted word did not enter stage 1");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (valid_reg == '1) && !result.ready)
        else $error("input blocked while a bubble exists");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[Stages-2] && valid_reg[Stages-1] && !result.ready
        |=> valid_reg[Stages-2] && $stable(s5_acc_reg))
        else $error("stage 5 word lost under stall");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.saturated
        |-> (result.new_value == SAT_MAX) || (result.new_value == SAT_MIN))
        else $error("saturated word not at a bound");
`endif

endmodule

@@ test/upwind_advection_diffusion_point_tb.sv @@
// Self-checking testbench for the upwind advection-diffusion point update pipeline.
module upwind_advection_diffusion_point_tb;
    import uadp_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RUN_LIMIT    = 5_000_000;
    localparam int UNMAPPED_REG = 7;
    localparam int LONG_HOLD    = 80;
    localparam int ONE          = 65536;            // 1.0 in Q16.16
    localparam int FMAX         = int'(SAT_MAX);
    localparam int FMIN         = int'(SAT_MIN);
    localparam int WideW        = 128;              // exact width for the predictor

    // One grid point as it enters the block.
    typedef struct {
        logic                    opcode;
        logic signed [DataW-1:0] center;
        logic signed [DataW-1:0] west;
        logic signed [DataW-1:0] east;
        logic signed [DataW-1:0] south;
        logic signed [DataW-1:0] north;
        logic signed [DataW-1:0] u_vel;
        logic signed [DataW-1:0] v_vel;
        logic signed [DataW-1:0] t_west;
        logic signed [DataW-1:0] t_east;
    } point_t;

    // One updated value as it leaves the block.
    typedef struct {
        logic signed [DataW-1:0] value;
        logic                    sat;
    } update_t;

    // Holds a private copy of the gains and the queue of updates still owed by the block.
    class stencil_board;
        logic [GainW-1:0] gains [7];
        update_t          pending_updates [$];
        int               errors;

        function new();
            gains[REG_ADV_GAIN_X]       = ADV_GAIN_RESET;
            gains[REG_ADV_GAIN_Y]       = ADV_GAIN_RESET;
            gains[REG_VORT_DIFF_GAIN_X] = DIFF_GAIN_RESET;
            gains[REG_VORT_DIFF_GAIN_Y] = DIFF_GAIN_RESET;
            gains[REG_TEMP_DIFF_GAIN_X] = DIFF_GAIN_RESET;
            gains[REG_TEMP_DIFF_GAIN_Y] = DIFF_GAIN_RESET;
            gains[REG_BUOYANCY_GAIN]    = BUOY_GAIN_RESET;
            errors = 0;
        endfunction

        // Keep the low 31 bits; writes to an unmapped index are dropped.
        function void set_gain(int idx, logic [ApbW-1:0] value);
            if (idx >= 0 && idx <= int'(REG_BUOYANCY_GAIN))
                gains[idx[2:0]] = value[GainW-1:0];
        endfunction

        // Form the whole sum exactly at 2^-48 weight, round half up, then clamp.
        function update_t stencil_update(point_t p);
            logic signed [WideW-1:0] cc, ww, ee, ss, nn, uu, vv, tw, te;
            logic signed [WideW-1:0] ax, ay, gx, gy, bg, ddx, ddy, acc, diff_sum, rnd;
            update_t r;
            cc = WideW'(p.center);
            ww = WideW'(p.west);
            ee = WideW'(p.east);
            ss = WideW'(p.south);
            nn = WideW'(p.north);
            uu = WideW'(p.u_vel);
            vv = WideW'(p.v_vel);
            tw = WideW'(p.t_west);
            te = WideW'(p.t_east);
            ax = WideW'(gains[REG_ADV_GAIN_X]);
            ay = WideW'(gains[REG_ADV_GAIN_Y]);
            bg = WideW'(gains[REG_BUOYANCY_GAIN]);
            if (p.opcode == OP_TEMPERATURE)
            begin
                gx = WideW'(gains[REG_TEMP_DIFF_GAIN_X]);
                gy = WideW'(gains[REG_TEMP_DIFF_GAIN_Y]);
            end
            else
            begin
                gx = WideW'(gains[REG_VORT_DIFF_GAIN_X]);
                gy = WideW'(gains[REG_VORT_DIFF_GAIN_Y]);
            end
            // upwind: backward difference for positive velocity, forward otherwise
            ddx = (uu > 0) ? cc - ww : ee - cc;
            ddy = (vv > 0) ? cc - ss : nn - cc;
            acc = (cc <<< 32) - ax * uu * ddx - ay * vv * ddy;
            diff_sum = gx * (ee - 2 * cc + ww) + gy * (nn - 2 * cc + ss);
            if (p.opcode == OP_VORTICITY)
                diff_sum = diff_sum - bg * (te - tw);
            acc = acc + (diff_sum <<< 16) + (WideW'(1) <<< 31);
            rnd = acc >>> 32;
            if (rnd > WideW'($signed(SAT_MAX)))
            begin
                r.value = SAT_MAX;
                r.sat   = 1'b1;
            end
            else if (rnd < WideW'($signed(SAT_MIN)))
            begin
                r.value = SAT_MIN;
                r.sat   = 1'b1;
            end
            else
            begin
                r.value = rnd[DataW-1:0];
                r.sat   = 1'b0;
            end
            return r;
        endfunction

        function void note_point(point_t p);
            pending_updates.push_back(stencil_update(p));
        endfunction

        function void check_word(logic signed [DataW-1:0] value, logic sat);
            update_t want;
            if (pending_updates.size() == 0)
            begin
                $display("%0t: result word value %h sat %b with no update pending",
                         $time, value, sat);
                errors++;
                return;
            end
            want = pending_updates.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: new_value expected %h actual %h", $time, want.value, value);
                errors++;
            end
            if (sat !== want.sat)
            begin
                $display("%0t: saturated expected %b actual %b", $time, want.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [ApbW-1:0]  pwdata;
    logic [ApbW-1:0]  prdata;
    logic             pready;

    // quiet turns off idling on both sides; hold_cycles requests one long receiver stall.
    bit               quiet;
    int               hold_cycles;
    stencil_board     board;

    uadp_item_if   item_ch ();
    uadp_result_if result_ch ();

    upwind_advection_diffusion_point u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hard stop in case the block hangs or drops a word.
    initial
    begin
        #(RUN_LIMIT);
        $display("upwind_advection_diffusion_point_tb: done, errors");
        $finish;
    end

    // Build a directed point from plain integers (raw Q16.16).
    function automatic point_t mk_point(logic op, int c, int w, int e, int s, int n,
                                        int u, int v, int tw, int te);
        point_t p;
        p.opcode = op;
        p.center = c;  p.west  = w;  p.east  = e;  p.south  = s;  p.north  = n;
        p.u_vel  = u;  p.v_vel = v;  p.t_west = tw; p.t_east = te;
        return p;
    endfunction

    // Mostly values of a few units so results stay in range; the rest full range or extremes.
    function automatic logic signed [DataW-1:0] rand_field();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return int'($urandom_range(0, 2 * 16 * ONE)) - 16 * ONE;
        else if (pick < 85)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return SAT_MIN;
            1: return SAT_MAX;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.opcode = 1'($urandom_range(0, 1));
        p.center = rand_field();
        p.west   = rand_field();
        p.east   = rand_field();
        p.south  = rand_field();
        p.north  = rand_field();
        // zero velocity takes the forward difference, so give it a fair share
        p.u_vel  = ($urandom_range(0, 9) == 0) ? '0 : rand_field();
        p.v_vel  = ($urandom_range(0, 9) == 0) ? '0 : rand_field();
        p.t_west = rand_field();
        p.t_east = rand_field();
        return p;
    endfunction

    // Gains: mostly up to 2.0 in Q16.16, some full range, some at the extremes.
    // Bit 31 is noise the block must drop.
    function automatic logic [ApbW-1:0] pick_gain();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return ($urandom & 32'h8000_0000) | $urandom_range(0, 2 * ONE);
        else if (pick < 8)
            return $urandom;
        return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
    endfunction

    // Setup phase, access phase, then an idle gap so back-to-back writes never
    // lower and raise psel in the same step.
    task automatic write_gain(int idx, logic [ApbW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_gain(idx, value);
        @(posedge clk);
    endtask

    task automatic write_all_gains();
        for (int i = int'(REG_ADV_GAIN_X); i <= int'(REG_BUOYANCY_GAIN); i++)
            write_gain(i, pick_gain());
    endtask

    // Offer one word, maybe after a random gap, and hold it until the block takes it.
    task automatic send_point(point_t p);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= p.opcode;
        item_ch.center_value <= p.center;
        item_ch.west_value   <= p.west;
        item_ch.east_value   <= p.east;
        item_ch.south_value  <= p.south;
        item_ch.north_value  <= p.north;
        item_ch.x_velocity   <= p.u_vel;
        item_ch.y_velocity   <= p.v_vel;
        item_ch.temp_west    <= p.t_west;
        item_ch.temp_east    <= p.t_east;
        @(posedge clk);
        while (item_ch.ready !== 1'b1) @(posedge clk);
        board.note_point(p);
    endtask

    task automatic run_points(int count);
        for (int i = 0; i < count; i++)
            send_point(random_point());
        item_ch.valid <= 1'b0;
    endtask

    // Wait for every owed update, then let the pipeline empty out.
    task automatic settle();
        while (board.pending_updates.size() != 0) @(posedge clk);
        repeat (Stages + 4) @(posedge clk);
    endtask

    // Check every result word the block hands over.
    always @(posedge clk)
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            board.check_word(result_ch.new_value, result_ch.saturated);

    // Receiver: random stalls, plus one long hold-off on request so the pipe backs up.
    initial
    begin
        int held;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                held = hold_cycles;
                hold_cycles = 0;
                result_ch.ready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Main sequence: reset, directed points, then phases of random points under
    // different gain settings.
    initial
    begin
        board = new();
        quiet = 1'b0;
        hold_cycles = 0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.opcode       <= OP_VORTICITY;
        item_ch.center_value <= '0;
        item_ch.west_value   <= '0;
        item_ch.east_value   <= '0;
        item_ch.south_value  <= '0;
        item_ch.north_value  <= '0;
        item_ch.x_velocity   <= '0;
        item_ch.y_velocity   <= '0;
        item_ch.temp_west    <= '0;
        item_ch.temp_east    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset gains.
        // All zero, both operations.
        send_point(mk_point(OP_VORTICITY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_point(mk_point(OP_TEMPERATURE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Positive then negative velocity: backward then forward differences.
        send_point(mk_point(OP_VORTICITY, ONE, ONE / 2, 2 * ONE, -ONE, 3 * ONE,
                            ONE, ONE, 0, ONE));
        send_point(mk_point(OP_VORTICITY, ONE, ONE / 2, 2 * ONE, -ONE, 3 * ONE,
                            -ONE, -ONE, 0, ONE));
        send_point(mk_point(OP_TEMPERATURE, ONE, ONE / 2, 2 * ONE, -ONE, 3 * ONE,
                            ONE, -ONE, ONE, 0));
        // Zero velocity: the forward difference is picked and its term vanishes.
        send_point(mk_point(OP_TEMPERATURE, 5 * ONE, ONE, -ONE, 2 * ONE, 7 * ONE,
                            0, 0, 0, 0));
        // Smallest nonzero velocities.
        send_point(mk_point(OP_VORTICITY, 3 * ONE, ONE, -ONE, 2 * ONE, 7 * ONE,
                            1, -1, -ONE, ONE));
        // Temperature update ignores the buoyancy temperatures.
        send_point(mk_point(OP_TEMPERATURE, ONE, 0, 0, 0, 0, 0, 0, FMIN, FMAX));
        // Large buoyancy drive on vorticity.
        send_point(mk_point(OP_VORTICITY, ONE, 0, 0, 0, 0, 0, 0, FMIN, FMAX));
        // Every field at its extremes.
        send_point(mk_point(OP_VORTICITY, FMAX, FMAX, FMAX, FMAX, FMAX,
                            FMAX, FMAX, FMAX, FMAX));
        send_point(mk_point(OP_VORTICITY, FMIN, FMIN, FMIN, FMIN, FMIN,
                            FMIN, FMIN, FMIN, FMIN));
        send_point(mk_point(OP_TEMPERATURE, FMAX, FMAX, FMAX, FMAX, FMAX,
                            FMAX, FMAX, FMAX, FMAX));
        send_point(mk_point(OP_TEMPERATURE, FMIN, FMIN, FMIN, FMIN, FMIN,
                            FMIN, FMIN, FMIN, FMIN));
        // Clamp high, then clamp low, through the buoyancy term.
        send_point(mk_point(OP_VORTICITY, FMAX, FMAX, FMAX, FMAX, FMAX,
                            0, 0, FMAX, FMIN));
        send_point(mk_point(OP_VORTICITY, FMIN, FMIN, FMIN, FMIN, FMIN,
                            0, 0, FMIN, FMAX));
        // Extreme velocities of opposite sign against a steep neighbor field.
        send_point(mk_point(OP_TEMPERATURE, 0, FMIN, FMAX, FMAX, FMIN,
                            FMIN, FMAX, 0, 0));
        item_ch.valid <= 1'b0;
        settle();

        // Random gains, random points.
        write_all_gains();
        run_points(250);
        settle();

        // Every gain at its top value (bit 31 set too); poke the unmapped slot.
        for (int i = int'(REG_ADV_GAIN_X); i <= int'(REG_BUOYANCY_GAIN); i++)
            write_gain(i, 32'hFFFF_FFFF);
        write_gain(UNMAPPED_REG, $urandom);
        run_points(60);
        settle();

        // Every gain zero: the point passes through unchanged.
        for (int i = int'(REG_ADV_GAIN_X); i <= int'(REG_BUOYANCY_GAIN); i++)
            write_gain(i, 32'h0000_0000);
        run_points(60);
        settle();

        // Long receiver stall while points keep coming, so the input backs up.
        write_all_gains();
        hold_cycles = LONG_HOLD;
        run_points(200);
        settle();

        // Final stretch at full rate with no idling on either side.
        write_all_gains();
        quiet = 1'b1;
        run_points(280);
        settle();

        if (board.errors == 0)
            $display("upwind_advection_diffusion_point_tb: done, clean");
        else
            $display("upwind_advection_diffusion_point_tb: done, errors");
        $finish;
    end

endmodule
